@@ hdl/smde_pkg.sv @@
package smde_pkg;

  // fixed field widths
  localparam int COL_W = 4;
  localparam int ROW_W = 8;
  localparam int BIT_W = 3;
  localparam int SWITCH_W = COL_W + BIT_W;
  localparam int EVENT_W = COL_W + BIT_W + 1;

  // default matrix size
  localparam int NUM_COLUMNS_DEF = 16;

  // item kinds
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // write into both column stores
  typedef struct packed {
    logic en;
    logic [COL_W-1:0] addr;
    logic [ROW_W-1:0] prev;
    logic [ROW_W-1:0] deb;
  } store_wr_t;

  // lowest pending bit and what remains after it
  typedef struct packed {
    logic [BIT_W-1:0] idx;
    logic [ROW_W-1:0] rest;
  } pick_t;

endpackage

@@ hdl/smde_if.sv @@
interface smde_in_if;
  import smde_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row_bits;

  modport source (output valid, output kind, output column, output row_bits, input ready);
  modport sink (input valid, input kind, input column, input row_bits, output ready);
endinterface

interface smde_out_if;
  import smde_pkg::*;
  logic valid;
  logic ready;
  logic [SWITCH_W-1:0] switch_number;
  logic [EVENT_W-1:0] event_index;
  logic active;
  logic last;

  modport source (output valid, output switch_number, output event_index, output active,
                  output last, input ready);
  modport sink (input valid, input switch_number, input event_index, input active,
                input last, output ready);
endinterface

@@ hdl/smde_store.sv @@
module smde_store
  import smde_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  store_wr_t wr,
  input  logic [COL_W-1:0] rd_addr,
  output logic [ROW_W-1:0] rd_prev,
  output logic [ROW_W-1:0] rd_deb
);

  localparam int IdxW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

  logic [ROW_W-1:0] prev_rows [NUM_COLUMNS];
  logic [ROW_W-1:0] deb_rows [NUM_COLUMNS];
  logic rd_ok;

  // previous sample and debounced state per column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        prev_rows[i] <= '0;
        deb_rows[i] <= '0;
      end
    end else if (wr.en && ({1'b0, wr.addr} < (COL_W + 1)'(NUM_COLUMNS))) begin
      prev_rows[wr.addr[IdxW-1:0]] <= wr.prev;
      deb_rows[wr.addr[IdxW-1:0]] <= wr.deb;
    end
  end

  // read of the addressed column, zero outside the matrix
  assign rd_ok = {1'b0, rd_addr} < (COL_W + 1)'(NUM_COLUMNS);
  assign rd_prev = rd_ok ? prev_rows[rd_addr[IdxW-1:0]] : '0;
  assign rd_deb = rd_ok ? deb_rows[rd_addr[IdxW-1:0]] : '0;

endmodule

@@ hdl/smde_pick.sv @@
module smde_pick
  import smde_pkg::*;
(
  input  logic [ROW_W-1:0] mask,
  output pick_t pick
);

  // priority encode the lowest set bit
  always_comb begin
    pick.idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick.idx = BIT_W'(i);
      end
    end
    pick.rest = mask & (mask - ROW_W'(1));
  end

endmodule

@@ hdl/switch_matrix_debounce_events_top.sv @@
// first event: item latched, eval state updates the stores and sets the pending mask,
// emit state loads the output register; one event per cycle while the output does not
// stall, set by the single lowest-bit pick unit; a column outside the matrix is dropped
// input ready is high only while no item is being worked; output stalls hold the scan
// reset: both column stores clear to zero, no events pending, output empty
module switch_matrix_debounce_events_top
  import smde_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  logic clk,
  input  logic rst,
  smde_in_if.sink samples,
  smde_out_if.source events
);

  state_t state;
  state_t state_next;

  logic kind;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row_bits;
  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] mask_next;

  logic out_valid;
  logic load_out;
  logic [SWITCH_W-1:0] out_switch;
  logic [EVENT_W-1:0] out_event;
  logic out_active;
  logic out_last;

  store_wr_t wr;
  logic [ROW_W-1:0] rd_prev;
  logic [ROW_W-1:0] rd_deb;
  logic [ROW_W-1:0] accepted;
  pick_t pick;
  logic take;
  logic col_ok;

  smde_store #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .wr(wr),
    .rd_addr(column),
    .rd_prev(rd_prev),
    .rd_deb(rd_deb)
  );

  smde_pick u_pick (
    .mask(mask),
    .pick(pick)
  );

  assign samples.ready = (state == ST_IDLE);
  assign take = samples.valid && samples.ready;
  assign col_ok = {1'b0, samples.column} < (COL_W + 1)'(NUM_COLUMNS);

  // stable for two samples and different from the debounced state
  assign accepted = ~(row_bits ^ rd_prev) & (row_bits ^ rd_deb);

  // item latch
  always_ff @(posedge clk) begin
    if (take) begin
      kind <= samples.kind;
      column <= samples.column;
      row_bits <= samples.row_bits;
    end
  end

  // state and pending mask
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mask <= '0;
    end else begin
      state <= state_next;
      mask <= mask_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    mask_next = mask;
    load_out = 1'b0;
    wr = '0;
    case (state)
      ST_IDLE: begin
        if (take && col_ok) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        wr.en = 1'b1;
        wr.addr = column;
        wr.prev = row_bits;
        if (kind == KIND_PRELOAD) begin
          wr.deb = row_bits;
          mask_next = '0;
          state_next = ST_IDLE;
        end else begin
          wr.deb = rd_deb ^ accepted;
          mask_next = accepted;
          state_next = (accepted == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || events.ready) begin
          load_out = 1'b1;
          mask_next = pick.rest;
          if (pick.rest == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        mask_next = '0;
      end
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_switch <= {column, pick.idx};
      out_event <= {column, pick.idx, ~row_bits[pick.idx]};
      out_active <= ~row_bits[pick.idx];
      out_last <= (pick.rest == '0);
    end
  end

  assign events.valid = out_valid;
  assign events.switch_number = out_switch;
  assign events.event_index = out_event;
  assign events.active = out_active;
  assign events.last = out_last;

endmodule

@@ bench/tb_switch_matrix_debounce_events_top.sv @@
`timescale 1ns / 1ps

module tb_switch_matrix_debounce_events_top;
  import smde_pkg::*;

  localparam int NUM_COLS = NUM_COLUMNS_DEF;
  localparam int PLAN_LEN = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SWITCH_W-1:0] switch_number;
    logic [EVENT_W-1:0] event_index;
    logic active;
    logic last;
  } sw_event_t;

  localparam sw_event_t NO_EV = '0;

  // one directed item, with typed expectation where it is obvious
  typedef struct {
    logic kind;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_bits;
    bit typed;
    int n;
    sw_event_t first;
    sw_event_t fin;
  } plan_row_t;

  logic clk;
  logic rst;

  smde_in_if samples_if ();
  smde_out_if events_if ();

  switch_matrix_debounce_events_top u_top (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .events(events_if)
  );

  // debounce state as the block should hold it
  logic [ROW_W-1:0] stable_rows [NUM_COLS];
  logic [ROW_W-1:0] last_rows [NUM_COLS];
  sw_event_t pending_events [$];

  // summary of the most recent accepted item
  int pred_n;
  sw_event_t pred_first;
  sw_event_t pred_fin;

  int mismatches;
  bit idle_on;
  bit hold_off_req;
  plan_row_t plan [PLAN_LEN];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  function automatic sw_event_t ev(input int sw, input int idx, input bit act,
                                   input bit lst);
    sw_event_t e;
    e.switch_number = SWITCH_W'(sw);
    e.event_index = EVENT_W'(idx);
    e.active = act;
    e.last = lst;
    return e;
  endfunction

  function automatic void flag_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // two-sample debounce of one column sample, queues the change events
  task automatic debounce_sample(input logic k, input logic [COL_W-1:0] c,
                                 input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] hits;
    sw_event_t e;
    int n;
    n = 0;
    pred_n = 0;
    if (int'(c) >= NUM_COLS) return;
    if (k == KIND_PRELOAD) begin
      stable_rows[c] = r;
      last_rows[c] = r;
      return;
    end
    hits = ~(r ^ last_rows[c]) & (r ^ stable_rows[c]);
    last_rows[c] = r;
    for (int b = 0; b < ROW_W; b++) begin
      if (hits[b]) begin
        e.switch_number = {c, BIT_W'(b)};
        e.active = ~r[b];
        e.event_index = {c, BIT_W'(b), ~r[b]};
        e.last = ((hits >> (b + 1)) == '0);
        stable_rows[c][b] = ~stable_rows[c][b];
        pending_events.push_back(e);
        if (n == 0) pred_first = e;
        pred_fin = e;
        n++;
      end
    end
    pred_n = n;
  endtask

  // compare one accepted event against the oldest expectation
  task automatic check_event();
    sw_event_t got;
    sw_event_t want;
    got.switch_number = events_if.switch_number;
    got.event_index = events_if.event_index;
    got.active = events_if.active;
    got.last = events_if.last;
    if (pending_events.size() == 0) begin
      flag_mismatch($sformatf("unexpected event sw=%0d idx=%02h act=%0b last=%0b",
                              got.switch_number, got.event_index, got.active, got.last));
    end else begin
      want = pending_events.pop_front();
      if (got.switch_number !== want.switch_number || got.event_index !== want.event_index ||
          got.active !== want.active || got.last !== want.last) begin
        flag_mismatch($sformatf(
          "exp sw=%0d idx=%02h act=%0b last=%0b got sw=%0d idx=%02h act=%0b last=%0b",
          want.switch_number, want.event_index, want.active, want.last,
          got.switch_number, got.event_index, got.active, got.last));
      end
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (samples_if.valid && samples_if.ready)
        debounce_sample(samples_if.kind, samples_if.column, samples_if.row_bits);
      if (events_if.valid && events_if.ready) check_event();
    end
  end

  // event receiver: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    events_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        events_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        events_if.ready <= 1'b0;
        stall_left--;
      end else begin
        events_if.ready <= 1'b1;
      end
    end
  end

  // offer one item, starts and ends just after a falling edge
  task automatic send_sample(input logic k, input logic [COL_W-1:0] c,
                             input logic [ROW_W-1:0] r);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.kind <= k;
    samples_if.column <= c;
    samples_if.row_bits <= r;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random traffic, mostly stable repeated samples so changes get through
  task automatic scan_burst(input int items);
    int sent;
    int pick;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] v;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      c = COL_W'($urandom_range(0, NUM_COLS - 1));
      v = ROW_W'($urandom);
      if (pick < 10) begin
        send_sample(KIND_PRELOAD, c, v);
        sent++;
      end else if (pick < 25) begin
        send_sample(KIND_SCAN, c, v);
        sent++;
      end else begin
        // few flipped switches, or a whole new pattern
        if (pick < 60) v = stable_rows[c] ^ ROW_W'($urandom & $urandom);
        send_sample(KIND_SCAN, c, v);
        if ($urandom_range(0, 4) == 0) begin
          send_sample(KIND_SCAN, c, v ^ ROW_W'(1 << $urandom_range(0, ROW_W - 1)));
          send_sample(KIND_SCAN, c, v);
          sent += 2;
        end
        send_sample(KIND_SCAN, c, v);
        sent += 2;
        if ($urandom_range(0, 3) == 0) begin
          send_sample(KIND_SCAN, c, v);
          sent++;
        end
      end
    end
  endtask

  initial begin
    mismatches = 0;
    idle_on = 1'b1;
    hold_off_req = 1'b0;
    pred_n = 0;
    pred_first = NO_EV;
    pred_fin = NO_EV;
    for (int i = 0; i < NUM_COLS; i++) begin
      stable_rows[i] = '0;
      last_rows[i] = '0;
    end
    samples_if.valid = 1'b0;
    samples_if.kind = KIND_SCAN;
    samples_if.column = '0;
    samples_if.row_bits = '0;
    rst = 1'b1;

    // directed items: extremes, preload, bounce, single and full-column changes
    plan = '{
      '{KIND_SCAN, 4'd0, 8'h00, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd0, 8'hFF, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd0, 8'hFF, 1'b1, 8, ev(0, 'h00, 0, 0), ev(7, 'h0E, 0, 1)},
      '{KIND_SCAN, 4'd15, 8'hFF, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd15, 8'hFF, 1'b1, 8, ev(120, 'hF0, 0, 0), ev(127, 'hFE, 0, 1)},
      '{KIND_SCAN, 4'd15, 8'h00, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd15, 8'h00, 1'b1, 8, ev(120, 'hF1, 1, 0), ev(127, 'hFF, 1, 1)},
      '{KIND_PRELOAD, 4'd3, 8'hA5, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd3, 8'hA5, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd3, 8'h5A, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd3, 8'h5A, 1'b1, 8, ev(24, 'h31, 1, 0), ev(31, 'h3F, 1, 1)},
      '{KIND_SCAN, 4'd7, 8'h80, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd7, 8'h80, 1'b1, 1, ev(63, 'h7E, 0, 1), ev(63, 'h7E, 0, 1)},
      '{KIND_SCAN, 4'd7, 8'h81, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd7, 8'h80, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_PRELOAD, 4'd7, 8'h00, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd7, 8'h00, 1'b1, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd9, 8'h3C, 1'b0, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd9, 8'h3C, 1'b0, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd9, 8'h24, 1'b0, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd9, 8'h24, 1'b0, 0, NO_EV, NO_EV},
      '{KIND_PRELOAD, 4'd0, 8'hFF, 1'b0, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd0, 8'h7F, 1'b0, 0, NO_EV, NO_EV},
      '{KIND_SCAN, 4'd0, 8'h7F, 1'b0, 0, NO_EV, NO_EV}
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed part, typed rows cross-check the prediction
    foreach (plan[i]) begin
      send_sample(plan[i].kind, plan[i].column, plan[i].row_bits);
      if (plan[i].typed) begin
        if (pred_n != plan[i].n)
          flag_mismatch($sformatf("item %0d: exp %0d events, predicted %0d",
                                  i, plan[i].n, pred_n));
        else if (pred_n > 0 && (pred_first !== plan[i].first || pred_fin !== plan[i].fin))
          flag_mismatch($sformatf("item %0d: exp first %h last %h, predicted %h %h",
                                  i, plan[i].first, plan[i].fin, pred_first, pred_fin));
      end
    end

    // random traffic with gaps
    scan_burst(40);

    // long receiver hold-off while items keep coming
    hold_off_req = 1'b1;
    scan_burst(30);

    // sender waits for every event to drain
    samples_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);

    // stretch with no gaps on either side
    idle_on = 1'b0;
    scan_burst(25);
    idle_on = 1'b1;
    scan_burst(25);

    // drain
    samples_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
